@@ hdl/ttdb_pkg.sv @@
// Shared constants, payload types and helper functions for the tilt-to-drive block.
package ttdb_pkg;

   // Fraction bits of the angle outputs and number of CORDIC rotation cells
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int CORDIC_STAGES   = 16;

   // Accumulator holds degrees in units of 2^-16
   localparam int ACC_FRAC    = 16;
   localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);
   localparam int ANGLE_SCALE = 1 << ANGLE_FRAC_BITS;

   // Square root: 48-bit radicand, one root bit per cell
   localparam int SQRT_CELLS = 24;

   // Rate divide by 131000 = 8 * 16375. With a = |gyro * lead| = 2b + c:
   // (a * 65536 + 65500) / 131000 = b + (9b + 8192c + 8187) / 16375,
   // the last quotient taken by reciprocal multiply, exact below 2^28.
   localparam int          DIV_LAT          = 3;
   localparam logic [27:0] RATE_BIAS_Q      = 28'd8187;
   localparam logic [27:0] RATE_ODD_ADD     = 28'd8192;
   localparam logic [28:0] RATE_RECIP       = 29'd268582994;
   localparam int          RATE_RECIP_SHIFT = 42;

   // Both branches meet after the same number of cycles
   localparam int CORE_LAT = (DIV_LAT > SQRT_CELLS + CORDIC_STAGES) ?
                             DIV_LAT : SQRT_CELLS + CORDIC_STAGES;
   localparam int PAD_CZ  = CORE_LAT - SQRT_CELLS - CORDIC_STAGES;
   localparam int PAD_DIV = CORE_LAT - DIV_LAT;

   // Lead time register reset value, ms
   localparam logic [9:0] LEAD_RESET = 10'd100;

   // Band bounds in tenths of a degree
   localparam int B0_HI = 30;
   localparam int B1_LO = 31;
   localparam int B1_HI = 90;
   localparam int B2_LO = 91;
   localparam int B2_HI = 150;
   localparam int B3_LO = 151;
   localparam int B3_HI = 300;

   // Speed codes
   localparam logic [1:0] SPEED_50 = 2'd0;
   localparam logic [1:0] SPEED_60 = 2'd1;
   localparam logic [1:0] SPEED_90 = 2'd2;
   localparam logic [1:0] SPEED_99 = 2'd3;

   typedef struct packed {
      logic [47:0]        n;     // radicand, consumed two bits a cell
      logic [26:0]        rem;
      logic [23:0]        q;
      logic signed [15:0] ax;    // carried to the CORDIC input
   } sqrt_type;

   typedef struct packed {
      logic [24:0] q;            // rate magnitude, 2^-16 degree
      logic        neg;
   } div_type;

   typedef struct packed {
      logic signed [26:0] x;
      logic signed [26:0] y;
      logic signed [25:0] z;
      logic [4:0]         idx;
   } cordic_type;

   typedef struct packed {
      logic       valid;
      logic       reverse;
      logic [1:0] code;
   } drive_type;

   // atan(2^-i) in degrees, 2^-16 units, rounded to nearest
   function automatic logic signed [25:0] atan_deg(input logic [4:0] i);
      logic signed [25:0] a;
      case (i)
         5'd0:  a = 26'sd2949120;
         5'd1:  a = 26'sd1740967;
         5'd2:  a = 26'sd919879;
         5'd3:  a = 26'sd466945;
         5'd4:  a = 26'sd234379;
         5'd5:  a = 26'sd117304;
         5'd6:  a = 26'sd58666;
         5'd7:  a = 26'sd29335;
         5'd8:  a = 26'sd14668;
         5'd9:  a = 26'sd7334;
         5'd10: a = 26'sd3667;
         5'd11: a = 26'sd1833;
         5'd12: a = 26'sd917;
         5'd13: a = 26'sd458;
         5'd14: a = 26'sd229;
         5'd15: a = 26'sd115;
         5'd16: a = 26'sd57;
         5'd17: a = 26'sd29;
         5'd18: a = 26'sd14;
         5'd19: a = 26'sd7;
         5'd20: a = 26'sd4;
         5'd21: a = 26'sd2;
         5'd22: a = 26'sd1;
         default: a = 26'sd0;
      endcase
      return a;
   endfunction

   // Shift down to output fraction, round half away from zero, saturate
   function automatic logic signed [15:0] round_sat(input logic signed [26:0] v);
      logic [26:0]        mag;
      logic [26:0]        r;
      logic signed [27:0] sv;
      mag = v[26] ? 27'(-v) : 27'(v);
      r   = (mag + 27'(ROUND_HALF)) >> ROUND_SHIFT;
      sv  = v[26] ? -$signed({1'b0, r}) : $signed({1'b0, r});
      if (sv > 28'sd32767) return 16'sh7fff;
      if (sv < -28'sd32768) return 16'sh8000;
      return 16'(sv);
   endfunction

   // Band ladder on predicted angle, strict bounds
   function automatic drive_type band_map(input logic signed [15:0] p);
      int        p10;
      drive_type d;
      p10 = int'(p) * 10;
      d   = '0;
      if (p10 > 0 && p10 < B0_HI * ANGLE_SCALE) begin
         d = '{valid: 1'b1, reverse: 1'b0, code: SPEED_50};
      end else if (p10 > B1_LO * ANGLE_SCALE && p10 < B1_HI * ANGLE_SCALE) begin
         d = '{valid: 1'b1, reverse: 1'b0, code: SPEED_60};
      end else if (p10 > B2_LO * ANGLE_SCALE && p10 < B2_HI * ANGLE_SCALE) begin
         d = '{valid: 1'b1, reverse: 1'b0, code: SPEED_90};
      end else if (p10 > B3_LO * ANGLE_SCALE && p10 < B3_HI * ANGLE_SCALE) begin
         d = '{valid: 1'b1, reverse: 1'b0, code: SPEED_99};
      end else if ((p10 < 0 && p10 > -B0_HI * ANGLE_SCALE) ||
                   (p10 < -B1_LO * ANGLE_SCALE && p10 > -B1_HI * ANGLE_SCALE) ||
                   (p10 < -B2_LO * ANGLE_SCALE && p10 > -B2_HI * ANGLE_SCALE) ||
                   (p10 < -B3_LO * ANGLE_SCALE && p10 > -B3_HI * ANGLE_SCALE)) begin
         d = '{valid: 1'b1, reverse: 1'b1, code: SPEED_50};
      end
      return d;
   endfunction

endpackage

@@ hdl/ttdb_if.sv @@
// Valid/ready channel interfaces for IMU samples and drive results.
interface ttdb_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   modport source(output valid, accel_x, accel_y, accel_z, gyro_x, input ready);
   modport sink(input valid, accel_x, accel_y, accel_z, gyro_x, output ready);
endinterface

interface ttdb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] predicted_angle;
   logic               drive_valid;
   logic               drive_reverse;
   logic [1:0]         speed_code;
   modport source(output valid, pitch_angle, predicted_angle, drive_valid,
                  drive_reverse, speed_code, input ready);
   modport sink(input valid, pitch_angle, predicted_angle, drive_valid,
                drive_reverse, speed_code, output ready);
endinterface

@@ hdl/tilt_to_drive_band_top.sv @@
// Top level: IMU sample to pitch, predicted pitch and drive band command.
//
//   channel   dir   payload                                          handshake
//   req_ch    in    accel_x, accel_y, accel_z, gyro_x                valid/ready
//   rsp_ch    out   pitch_angle, predicted_angle, drive_valid,       valid/ready
//                   drive_reverse, speed_code
//   csr_*     in    lead_time_ms                                     write enable
//
// One sample enters per cycle unless the output stalls; each accepted request passes
// in order through the entry register, 24 square-root cells, 16 CORDIC cells and
// the output register. The three-stage rate divider runs beside them, padded.
// Reset clears the valid chain and loads lead_time_ms with 100.
// A stalled output freezes the whole row; req_ch.ready follows rsp_ch.ready
// then, so a transfer on each side can happen in the same cycle.
module tilt_to_drive_band_top (
   input  logic       clock,
   input  logic       reset,
   ttdb_req_if.sink   req_ch,
   ttdb_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic [9:0] csr_wr_data
);
   localparam int VLD_LEN = ttdb_pkg::CORE_LAT + 2;

   logic [9:0]          lead_ff;
   logic                adv;
   logic [VLD_LEN-1:0]  vld_ff, vld_in;

   logic [30:0]         ay2_ff, az2_ff;
   logic signed [26:0]  gl_ff;
   logic signed [15:0]  ax_ff;

   logic [31:0]         sq;
   logic [26:0]         gl_mag;

   ttdb_pkg::sqrt_type   sq_ch [0:ttdb_pkg::SQRT_CELLS];
   ttdb_pkg::cordic_type cz_ch [0:ttdb_pkg::CORDIC_STAGES];
   logic signed [25:0]   zp_ch [0:ttdb_pkg::PAD_CZ];
   ttdb_pkg::div_type    dp_ch [0:ttdb_pkg::PAD_DIV];

   logic signed [25:0]  rate;
   logic signed [26:0]  pred_sum;
   logic signed [15:0]  pitch_in, pred_in;
   ttdb_pkg::drive_type drv_in;

   logic signed [15:0]  pitch_ff, pred_ff;
   ttdb_pkg::drive_type drv_ff;

   // Lead time register
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= ttdb_pkg::LEAD_RESET;
      end else if (csr_wr_en) begin
         lead_ff <= csr_wr_data;
      end
   end

   // Whole row advances unless the output holds an untaken result
   assign adv          = !vld_ff[VLD_LEN-1] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign vld_in       = {vld_ff[VLD_LEN-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Entry stage: squares and rate product
   always_ff @(posedge clock) begin
      if (adv) begin
         ay2_ff <= 31'(32'(req_ch.accel_y) * 32'(req_ch.accel_y));
         az2_ff <= 31'(32'(req_ch.accel_z) * 32'(req_ch.accel_z));
         gl_ff  <= 27'(req_ch.gyro_x) * $signed({17'd0, lead_ff});
         ax_ff  <= req_ch.accel_x;
      end
   end

   // Feed the square-root row and the rate divider
   assign sq       = 32'(ay2_ff) + 32'(az2_ff);
   assign gl_mag   = gl_ff[26] ? 27'(-gl_ff) : 27'(gl_ff);
   assign sq_ch[0] = '{n: {sq, 16'd0}, rem: '0, q: '0, ax: ax_ff};

   for (genvar k = 0; k < ttdb_pkg::SQRT_CELLS; k++) begin : g_sqrt
      ttdb_sqrt_cell u_cell (
         .clock(clock), .adv(adv), .cell_in(sq_ch[k]), .cell_out(sq_ch[k+1])
      );
   end

   ttdb_div_cell u_rate_div (
      .clock(clock), .adv(adv), .mag(gl_mag[24:0]), .neg(gl_ff[26]),
      .cell_out(dp_ch[0])
   );

   // CORDIC start vector: x = root, y = -ax * 256
   assign cz_ch[0] = '{x:   $signed({3'd0, sq_ch[ttdb_pkg::SQRT_CELLS].q}),
                       y:   (-27'(sq_ch[ttdb_pkg::SQRT_CELLS].ax)) <<< 8,
                       z:   '0,
                       idx: '0};

   for (genvar k = 0; k < ttdb_pkg::CORDIC_STAGES; k++) begin : g_cordic
      ttdb_cordic_cell u_cell (
         .clock(clock), .adv(adv), .cell_in(cz_ch[k]), .cell_out(cz_ch[k+1])
      );
   end

   // Balance the two branches
   assign zp_ch[0] = cz_ch[ttdb_pkg::CORDIC_STAGES].z;

   for (genvar k = 0; k < ttdb_pkg::PAD_CZ; k++) begin : g_zpad
      always_ff @(posedge clock) begin
         if (adv) zp_ch[k+1] <= zp_ch[k];
      end
   end

   for (genvar k = 0; k < ttdb_pkg::PAD_DIV; k++) begin : g_dpad
      always_ff @(posedge clock) begin
         if (adv) dp_ch[k+1] <= dp_ch[k];
      end
   end

   // Sum, round, saturate, band lookup
   always_comb begin
      rate = dp_ch[ttdb_pkg::PAD_DIV].neg ? -$signed({1'b0, dp_ch[ttdb_pkg::PAD_DIV].q})
                                          :  $signed({1'b0, dp_ch[ttdb_pkg::PAD_DIV].q});
      pred_sum = 27'(zp_ch[ttdb_pkg::PAD_CZ]) + 27'(rate);
      pitch_in = ttdb_pkg::round_sat(27'(zp_ch[ttdb_pkg::PAD_CZ]));
      pred_in  = ttdb_pkg::round_sat(pred_sum);
      drv_in   = ttdb_pkg::band_map(pred_in);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (adv) begin
         pitch_ff <= pitch_in;
         pred_ff  <= pred_in;
         drv_ff   <= drv_in;
      end
   end

   assign rsp_ch.valid           = vld_ff[VLD_LEN-1];
   assign rsp_ch.pitch_angle     = pitch_ff;
   assign rsp_ch.predicted_angle = pred_ff;
   assign rsp_ch.drive_valid     = drv_ff.valid;
   assign rsp_ch.drive_reverse   = drv_ff.reverse;
   assign rsp_ch.speed_code      = drv_ff.code;
endmodule

@@ hdl/ttdb_sqrt_cell.sv @@
// One restoring square-root cell: takes two radicand bits, yields one root bit.
module ttdb_sqrt_cell (
   input  logic              clock,
   input  logic              adv,
   input  ttdb_pkg::sqrt_type cell_in,
   output ttdb_pkg::sqrt_type cell_out
);
   ttdb_pkg::sqrt_type cell_ff, cell_in_w;
   logic [26:0] rem2;
   logic [26:0] trial;

   // Bring down two bits, try subtracting 4q+1
   always_comb begin
      rem2  = {cell_in.rem[24:0], cell_in.n[47:46]};
      trial = {1'b0, cell_in.q, 2'b01};
      cell_in_w    = cell_in;
      cell_in_w.n  = {cell_in.n[45:0], 2'b00};
      if (rem2 >= trial) begin
         cell_in_w.rem = rem2 - trial;
         cell_in_w.q   = {cell_in.q[22:0], 1'b1};
      end else begin
         cell_in_w.rem = rem2;
         cell_in_w.q   = {cell_in.q[22:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) cell_ff <= cell_in_w;
   end

   assign cell_out = cell_ff;
endmodule

@@ hdl/ttdb_div_cell.sv @@
// Three-stage rate divider: rate magnitude by reciprocal multiplication.
module ttdb_div_cell (
   input  logic              clock,
   input  logic              adv,
   input  logic [24:0]       mag,
   input  logic              neg,
   output ttdb_pkg::div_type cell_out
);
   logic [23:0]       half_ff, half2_ff;
   logic [27:0]       fold_ff, fold_in;
   logic [56:0]       prod_ff;
   logic              neg1_ff, neg2_ff;
   ttdb_pkg::div_type cell_ff, cell_in;

   // Fold the odd bit and bias: 9b + 8192c + 8187
   always_comb begin
      fold_in = 28'({mag[24:1], 3'b000}) + 28'(mag[24:1]) + ttdb_pkg::RATE_BIAS_Q;
      if (mag[0]) fold_in = fold_in + ttdb_pkg::RATE_ODD_ADD;
   end

   // Final quotient: b plus the folded part over 16375
   always_comb begin
      cell_in.q   = 25'(half2_ff) +
                    25'(prod_ff[56:ttdb_pkg::RATE_RECIP_SHIFT]);
      cell_in.neg = neg2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         half_ff  <= mag[24:1];
         fold_ff  <= fold_in;
         neg1_ff  <= neg;
         half2_ff <= half_ff;
         prod_ff  <= 57'(fold_ff) * 57'(ttdb_pkg::RATE_RECIP);
         neg2_ff  <= neg1_ff;
         cell_ff  <= cell_in;
      end
   end

   assign cell_out = cell_ff;
endmodule

@@ hdl/ttdb_cordic_cell.sv @@
// One vectoring CORDIC rotation cell; the cell index travels with the data.
module ttdb_cordic_cell (
   input  logic                clock,
   input  logic                adv,
   input  ttdb_pkg::cordic_type cell_in,
   output ttdb_pkg::cordic_type cell_out
);
   ttdb_pkg::cordic_type cell_ff, cell_in_w;
   logic signed [26:0] dx;
   logic signed [26:0] dy;
   logic signed [25:0] ang;

   // Rotate toward y = 0
   always_comb begin
      dx  = cell_in.y >>> cell_in.idx;
      dy  = cell_in.x >>> cell_in.idx;
      ang = ttdb_pkg::atan_deg(cell_in.idx);
      cell_in_w     = cell_in;
      cell_in_w.idx = cell_in.idx + 5'd1;
      if (cell_in.y > 27'sd0) begin
         cell_in_w.x = cell_in.x + dx;
         cell_in_w.y = cell_in.y - dy;
         cell_in_w.z = cell_in.z + ang;
      end else if (cell_in.y < 27'sd0) begin
         cell_in_w.x = cell_in.x - dx;
         cell_in_w.y = cell_in.y + dy;
         cell_in_w.z = cell_in.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) cell_ff <= cell_in_w;
   end

   assign cell_out = cell_ff;
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the tilt-to-drive band mapper.
module testbench;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [9:0] csr_wr_data;

   ttdb_req_if req_ch();
   ttdb_rsp_if rsp_ch();

   tilt_to_drive_band_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   typedef struct {
      logic signed [15:0] pitch;
      logic signed [15:0] pred;
      logic               dvalid;
      logic               rev;
      logic [1:0]         code;
   } drive_cmd_type;

   typedef struct {
      logic signed [15:0] ax, ay, az, gx;
      bit                 known;
      drive_cmd_type      cmd;
   } sample_row_type;

   localparam int LATENCY    = 41;
   localparam int CYCLE_CAP  = 400000;

   // Model copy of the lead time register
   logic [9:0]     lead_ms;
   drive_cmd_type  cmd_queue[$];
   int             fail_count;
   int             cycle_count = 0;
   bit             rsp_hold;
   bit             sample_phase_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // atan(2^-i) in 2^-16 degree
   function automatic longint atan_q16(input int i);
      longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
      return t[i];
   endfunction

   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint half_away_shift(input longint v, input int s);
      longint h;
      h = longint'(1) << (s - 1);
      if (v >= 0) return (v + h) >>> s;
      return -((-v + h) >>> s);
   endfunction

   function automatic longint clip16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint int_sqrt(input longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return longint'(root);
   endfunction

   // Pitch by vectoring CORDIC, rate lead, band ladder
   function automatic drive_cmd_type predict_drive(input logic signed [15:0] ax,
         input logic signed [15:0] ay, input logic signed [15:0] az,
         input logic signed [15:0] gx, input logic [9:0] lead);
      drive_cmd_type c;
      longint x, y, z, dx, dy, num, mag, rate, p, q, sc;
      sc = ttdb_pkg::ANGLE_SCALE;
      x = int_sqrt((longint'(ay) * ay + longint'(az) * az) << 16);
      y = -longint'(ax) * 256;
      z = 0;
      for (int i = 0; i < ttdb_pkg::CORDIC_STAGES; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += atan_q16(i);
         end else if (y < 0) begin
            x -= dx; y += dy; z -= atan_q16(i);
         end
      end
      num  = longint'(gx) * longint'(lead) * 65536;
      mag  = num < 0 ? -num : num;
      rate = (mag + 65500) / 131000;
      if (num < 0) rate = -rate;
      c.pitch = 16'(clip16(half_away_shift(z, ttdb_pkg::ROUND_SHIFT)));
      q = clip16(half_away_shift(z + rate, ttdb_pkg::ROUND_SHIFT));
      c.pred = 16'(q);
      p = q * 10;
      c.dvalid = 1'b1;
      c.rev = 1'b0;
      c.code = ttdb_pkg::SPEED_50;
      if (p > 0 && p < 30 * sc) c.code = ttdb_pkg::SPEED_50;
      else if (p > 31 * sc && p < 90 * sc) c.code = ttdb_pkg::SPEED_60;
      else if (p > 91 * sc && p < 150 * sc) c.code = ttdb_pkg::SPEED_90;
      else if (p > 151 * sc && p < 300 * sc) c.code = ttdb_pkg::SPEED_99;
      else if ((p < 0 && p > -30 * sc) || (p < -31 * sc && p > -90 * sc) ||
               (p < -91 * sc && p > -150 * sc) ||
               (p < -151 * sc && p > -300 * sc))
         c.rev = 1'b1;
      else
         c.dvalid = 1'b0;
      return c;
   endfunction

   // Directed table: extremes, zero vector, each band and one gap
   sample_row_type sample_table[] = '{
      '{0, 0, 0, 0, 1, '{0, 0, 0, 0, ttdb_pkg::SPEED_50}},
      '{0, 0, 16384, 0, 1, '{0, 0, 0, 0, ttdb_pkg::SPEED_50}},
      '{-32768, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
      '{32767, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
      '{-32768, -32768, -32768, -32768, 0, '{0, 0, 0, 0, 0}},
      '{32767, 32767, 32767, 32767, 0, '{0, 0, 0, 0, 0}},
      '{0, 0, 16384, 131, 0, '{0, 0, 0, 0, 0}},
      '{0, 0, 16384, -131, 0, '{0, 0, 0, 0, 0}},
      '{-1000, 0, 16384, 0, 0, '{0, 0, 0, 0, 0}},
      '{-2000, 0, 16384, 0, 0, '{0, 0, 0, 0, 0}},
      '{-3500, 0, 16384, 0, 0, '{0, 0, 0, 0, 0}},
      '{-6000, 0, 16384, 0, 0, '{0, 0, 0, 0, 0}},
      '{1000, 0, 16384, 0, 0, '{0, 0, 0, 0, 0}},
      '{2000, 0, 16384, 0, 0, '{0, 0, 0, 0, 0}},
      '{3500, 0, 16384, 0, 0, '{0, 0, 0, 0, 0}},
      '{6000, 0, 16384, 0, 0, '{0, 0, 0, 0, 0}},
      '{-870, 0, 16384, 0, 0, '{0, 0, 0, 0, 0}},
      '{-2580, 0, 16384, 0, 0, '{0, 0, 0, 0, 0}},
      '{0, -32768, 0, 32767, 0, '{0, 0, 0, 0, 0}},
      '{12345, 0, -16384, -32768, 0, '{0, 0, 0, 0, 0}}
   };

   task automatic write_lead(input logic [9:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      lead_ms = v;
   endtask

   // Offer one sample, queue its expected command at the transfer
   task automatic send_sample(input logic signed [15:0] ax, ay, az, gx,
                              input bit known, input drive_cmd_type c);
      drive_cmd_type e;
      int            idle;
      idle = $urandom_range(0, 3);
      if (idle != 0) begin
         req_ch.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.accel_x <= ax;
      req_ch.accel_y <= ay;
      req_ch.accel_z <= az;
      req_ch.gyro_x  <= gx;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      e = predict_drive(ax, ay, az, gx, lead_ms);
      if (known && (e.pitch != c.pitch || e.pred != c.pred || e.dvalid != c.dvalid ||
                    e.rev != c.rev || e.code != c.code)) begin
         $error("table row disagrees with prediction");
         fail_count++;
      end
      cmd_queue.push_back(known ? c : e);
   endtask

   // Stop offering and wait until every expected result has come
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (cmd_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic signed [15:0] tilt_count(input int deg10);
      // accel_x count for a pitch of roughly deg10 tenths of a degree at az 16384
      return 16'($rtoi(-16384.0 * $tan(deg10 * 3.14159265 / 1800.0)));
   endfunction

   // Sender: directed table, then random phases across lead settings
   initial begin
      logic [9:0] leads[6] = '{10'd0, 10'd1, 10'd1000, 10'd1023, 10'd100, 10'd250};
      drive_cmd_type none;
      logic signed [15:0] ax, ay, az, gx;
      none = '{0, 0, 0, 0, 0};
      fail_count = 0;
      sample_phase_done = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.accel_x = '0;
      req_ch.accel_y = '0;
      req_ch.accel_z = '0;
      req_ch.gyro_x = '0;
      lead_ms = ttdb_pkg::LEAD_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (sample_table[i])
         send_sample(sample_table[i].ax, sample_table[i].ay, sample_table[i].az,
                     sample_table[i].gx, sample_table[i].known, sample_table[i].cmd);
      drain_results();
      foreach (leads[k]) begin
         write_lead(leads[k]);
         for (int n = 0; n < 175; n++) begin
            if ($urandom_range(0, 3) != 0) begin
               // plausible tilt spread across the bands, small rate
               ay = 16'($signed($urandom_range(0, 2000)) - 1000);
               az = 16'($signed($urandom_range(12000, 17000)));
               if ($urandom_range(0, 1)) az = -az;
               ax = tilt_count($signed($urandom_range(0, 700)) - 350);
               gx = 16'($signed($urandom_range(0, 4000)) - 2000);
            end else begin
               ax = 16'($urandom); ay = 16'($urandom);
               az = 16'($urandom); gx = 16'($urandom);
            end
            send_sample(ax, ay, az, gx, 0, none);
         end
         // sender pause until the pipe is empty
         drain_results();
      end
      sample_phase_done = 1;
   end

   // Receiver: random idle per result, with one long hold-off
   initial begin
      drive_cmd_type e;
      int seen;
      int idle;
      seen = 0;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         idle = $urandom_range(0, 3);
         if (seen == 60 && !rsp_hold) begin
            rsp_hold = 1;
            idle = 150;
         end
         if (idle != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         seen++;
         if (cmd_queue.size() == 0) begin
            $error("result with no sample outstanding");
            fail_count++;
         end else begin
            e = cmd_queue.pop_front();
            if (rsp_ch.pitch_angle !== e.pitch) begin
               $error("pitch_angle exp %0d got %0d", e.pitch, rsp_ch.pitch_angle);
               fail_count++;
            end
            if (rsp_ch.predicted_angle !== e.pred) begin
               $error("predicted_angle exp %0d got %0d", e.pred,
                      rsp_ch.predicted_angle);
               fail_count++;
            end
            if (rsp_ch.drive_valid !== e.dvalid) begin
               $error("drive_valid exp %0d got %0d", e.dvalid, rsp_ch.drive_valid);
               fail_count++;
            end
            if (rsp_ch.drive_reverse !== e.rev) begin
               $error("drive_reverse exp %0d got %0d", e.rev, rsp_ch.drive_reverse);
               fail_count++;
            end
            if (rsp_ch.speed_code !== e.code) begin
               $error("speed_code exp %0d got %0d", e.code, rsp_ch.speed_code);
               fail_count++;
            end
         end
      end
   end

   // Finish once stimulus is drained
   initial begin
      wait (sample_phase_done);
      if (cmd_queue.size() != 0) begin
         $error("samples still awaiting results");
         fail_count++;
      end
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/ttdb_pkg.sv
hdl/ttdb_if.sv
hdl/ttdb_sqrt_cell.sv
hdl/ttdb_div_cell.sv
hdl/ttdb_cordic_cell.sv
hdl/tilt_to_drive_band_top.sv
tb/testbench.sv
